### design/omc_pkg.sv
// Shared types and constants for the overtaking maneuver controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package omc_pkg;

  // Moving machine states
  typedef enum logic [2:0] {
    MV_FORWARD       = 3'd0,
    MV_LEFT_LEFT     = 3'd1,
    MV_LEFT_RIGHT    = 3'd2,
    MV_CONTINUE_LEFT = 3'd3,
    MV_RIGHT_RIGHT   = 3'd4,
    MV_RIGHT_LEFT    = 3'd5
  } move_state_t;

  // Measuring machine states
  typedef enum logic [2:0] {
    MS_DISABLED      = 3'd0,
    MS_FIND_INIT     = 3'd1,
    MS_FIND          = 3'd2,
    MS_FIND_PLAUS    = 3'd3,
    MS_HAVE_BOTH_IR  = 3'd4,
    MS_IR_SAME_DIST  = 3'd5,
    MS_END_OF_OBJECT = 3'd6
  } measure_state_t;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_TRIGGER  = 2'd0;
  localparam logic [1:0] REG_PARALLEL = 2'd1;
  localparam logic [1:0] REG_APPROACH = 2'd2;

  localparam logic [14:0] TRIGGER_RESET  = 15'd450;
  localparam logic [14:0] PARALLEL_RESET = 15'd130;
  localparam logic [14:0] APPROACH_RESET = 15'd1;

  // Speed in tenths
  localparam logic [4:0] SPEED_FAST  = 5'd20;
  localparam logic [4:0] SPEED_TURN  = 5'd10;
  localparam logic [4:0] SPEED_SLOW  = 5'd9;
  localparam logic [4:0] SPEED_NONE  = 5'd0;

  // Fixed steering angles, hundredths
  localparam logic signed [15:0] STEER_LEFT_HARD = -16'sd2500;
  localparam logic signed [15:0] STEER_RIGHT     = 16'sd1500;
  localparam logic signed [15:0] STEER_RIGHT_LOW = 16'sd600;
  localparam logic signed [15:0] STEER_STRAIGHT  = 16'sd0;

  typedef struct packed {
    logic signed [15:0] lane_steering;
    logic signed [15:0] front_center_distance;
    logic signed [15:0] front_right_distance;
    logic signed [15:0] ir_front_right;
    logic signed [15:0] ir_rear_right;
  } omc_in_t;

  typedef struct packed {
    logic [4:0]         speed_tenths;
    logic signed [15:0] steering_out;
    logic [2:0]         moving_state;
    logic [2:0]         measuring_state;
  } omc_out_t;

  typedef struct packed {
    logic [14:0] trigger;
    logic [14:0] parallel;
    logic [14:0] approach;
  } omc_cfg_t;

  // Machine state shared between the moving and measuring logic
  typedef struct packed {
    move_state_t        mv;
    measure_state_t     ms;
    logic signed [15:0] prev_fc;
  } omc_stage_t;

endpackage
`default_nettype wire

### design/omc_move.sv
// Moving machine: speed, steering and turn counters for one tick.
// Depends on omc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module omc_move
  import omc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  omc_stage_t                stage,
  input  logic [COUNT_WIDTH-1:0]    first_ticks,
  input  logic [COUNT_WIDTH-1:0]    second_ticks,
  input  logic signed [15:0]        lane_steering,
  output omc_stage_t                stage_mid,
  output logic [COUNT_WIDTH-1:0]    first_mid,
  output logic [COUNT_WIDTH-1:0]    second_mid,
  output logic [4:0]                speed,
  output logic signed [15:0]        steer
);

  logic [COUNT_WIDTH-1:0] first_inc, second_inc, first_dec, second_dec;

  assign first_inc  = (first_ticks == '1) ? first_ticks : first_ticks + 1'b1;
  assign second_inc = (second_ticks == '1) ? second_ticks : second_ticks + 1'b1;
  assign first_dec  = (first_ticks == '0) ? first_ticks : first_ticks - 1'b1;
  assign second_dec = (second_ticks == '0) ? second_ticks : second_ticks - 1'b1;

  always_comb begin
    stage_mid  = stage;
    first_mid  = first_ticks;
    second_mid = second_ticks;
    speed      = SPEED_NONE;
    steer      = STEER_STRAIGHT;
    case (stage.mv)
      MV_FORWARD: begin
        speed      = SPEED_FAST;
        steer      = lane_steering;
        first_mid  = '0;
        second_mid = '0;
      end
      MV_LEFT_LEFT: begin
        speed        = SPEED_TURN;
        steer        = STEER_LEFT_HARD;
        stage_mid.ms = MS_HAVE_BOTH_IR;
        first_mid    = first_inc;
      end
      MV_LEFT_RIGHT: begin
        speed        = SPEED_TURN;
        steer        = STEER_RIGHT;
        stage_mid.ms = MS_IR_SAME_DIST;
        second_mid   = second_inc;
      end
      MV_CONTINUE_LEFT: begin
        speed        = SPEED_FAST;
        steer        = STEER_STRAIGHT;
        stage_mid.ms = MS_END_OF_OBJECT;
      end
      MV_RIGHT_RIGHT: begin
        speed     = SPEED_TURN;
        steer     = STEER_RIGHT_LOW;
        first_mid = first_dec;
        if (first_dec == '0) begin
          stage_mid.mv = MV_RIGHT_LEFT;
        end
      end
      MV_RIGHT_LEFT: begin
        speed      = SPEED_SLOW;
        steer      = STEER_LEFT_HARD;
        second_mid = second_dec;
        if (second_dec == '0) begin
          stage_mid.mv      = MV_FORWARD;
          stage_mid.ms      = MS_FIND_INIT;
          stage_mid.prev_fc = '0;
        end
      end
      default: ;  // undefined code holds, no drive
    endcase
  end

endmodule
`default_nettype wire

### design/omc_measure.sv
// Measuring machine: obstacle approach, parallel heading, end of obstacle.
// Depends on omc_pkg; runs on the state left by omc_move.
`timescale 1ns / 1ps
`default_nettype none
module omc_measure
  import omc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  omc_stage_t             stage_mid,
  input  logic [COUNT_WIDTH-1:0] first_ticks,
  input  logic [COUNT_WIDTH-1:0] second_ticks,
  input  omc_in_t                sample,
  input  omc_cfg_t               cfg,
  output omc_stage_t             stage_next
);

  logic signed [16:0] fc_diff, ir_diff;
  logic [16:0]        fc_mag, ir_mag;
  logic               approaching, parallel_ok, below_trigger;

  // previous - current, one bit wider so it cannot wrap
  assign fc_diff = {stage_mid.prev_fc[15], stage_mid.prev_fc}
                 - {sample.front_center_distance[15], sample.front_center_distance};
  assign ir_diff = {sample.ir_front_right[15], sample.ir_front_right}
                 - {sample.ir_rear_right[15], sample.ir_rear_right};
  assign fc_mag  = fc_diff[16] ? 17'(-fc_diff) : 17'(fc_diff);
  assign ir_mag  = ir_diff[16] ? 17'(-ir_diff) : 17'(ir_diff);

  assign approaching = (!sample.front_center_distance[15])
                    && (sample.front_center_distance != '0)
                    && ((!fc_diff[16] && fc_diff != '0) || (fc_mag < {2'b00, cfg.approach}));
  assign parallel_ok = (ir_mag < {2'b00, cfg.parallel}) && (second_ticks > first_ticks);
  assign below_trigger = sample.front_center_distance < $signed({1'b0, cfg.trigger});

  always_comb begin
    stage_next = stage_mid;
    case (stage_mid.ms)
      MS_FIND_INIT: begin
        stage_next.prev_fc = sample.front_center_distance;
        stage_next.ms      = MS_FIND;
      end
      MS_FIND: begin
        if (approaching) begin
          stage_next.ms = MS_FIND_PLAUS;
        end
        stage_next.prev_fc = sample.front_center_distance;
      end
      MS_FIND_PLAUS: begin
        if (below_trigger) begin
          stage_next.mv = MV_LEFT_LEFT;
          stage_next.ms = MS_DISABLED;
        end else begin
          stage_next.ms = MS_FIND;
        end
      end
      MS_HAVE_BOTH_IR: begin
        if (!sample.ir_front_right[15] && sample.ir_front_right != '0
            && !sample.ir_rear_right[15] && sample.ir_rear_right != '0) begin
          stage_next.mv = MV_LEFT_RIGHT;
        end
      end
      MS_IR_SAME_DIST: begin
        if (parallel_ok) begin
          stage_next.mv = MV_CONTINUE_LEFT;
        end
      end
      MS_END_OF_OBJECT: begin
        if (sample.front_right_distance[15]) begin
          stage_next.mv = MV_RIGHT_RIGHT;
          stage_next.ms = MS_DISABLED;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### design/overtaking_maneuver_controller_core.sv
// Top level of the overtaking maneuver controller: state, output register,
// APB register file. Depends on omc_pkg, omc_move and omc_measure.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   in_valid/in_ready/in_data carries one control tick: lane steering and
//   four distance readings (negative = no echo). out_valid/out_ready/out_data
//   returns one result per tick: speed, steering, and both machine states.
//   The result is registered: a tick transferred at a clock edge shows its
//   result at out_data from that edge on. One tick per cycle while the
//   receiver keeps taking results; the whole tick is one pass through the
//   moving and measuring logic between the state and output registers.
//   The input side is ready whenever the output register is empty or is
//   being taken in the same cycle, so a stalled receiver holds the result
//   and stops further transfers; nothing is dropped.
//   Reset (rst, synchronous, high): moving machine forward, measuring
//   machine at find-object init, counters and remembered distance zero,
//   output register empty, registers back to 450 / 130 / 1.
//   APB registers at 0x0 trigger distance, 0x4 parallel tolerance,
//   0x8 approach tolerance (15 bits each). Write only while idle.
module overtaking_maneuver_controller_core
  import omc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire omc_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output omc_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Machine state registers
  omc_stage_t             stage;
  omc_stage_t             stage_mid, stage_next;
  logic [COUNT_WIDTH-1:0] first_turn_ticks, second_turn_ticks;
  logic [COUNT_WIDTH-1:0] first_next, second_next;
  logic [4:0]             speed;
  logic signed [15:0]     steer;
  omc_cfg_t               cfg;
  logic                   accept, cfg_write;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // APB register file; writes beyond the third register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger  <= TRIGGER_RESET;
      cfg.parallel <= PARALLEL_RESET;
      cfg.approach <= APPROACH_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_TRIGGER:  cfg.trigger  <= pwdata[14:0];
        REG_PARALLEL: cfg.parallel <= pwdata[14:0];
        REG_APPROACH: cfg.approach <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TRIGGER:  prdata = {17'd0, cfg.trigger};
      REG_PARALLEL: prdata = {17'd0, cfg.parallel};
      REG_APPROACH: prdata = {17'd0, cfg.approach};
      default:      prdata = '0;
    endcase
  end

  // Moving machine runs first, measuring machine sees what it leaves
  omc_move #(.COUNT_WIDTH(COUNT_WIDTH)) u_move (
    .stage        (stage),
    .first_ticks  (first_turn_ticks),
    .second_ticks (second_turn_ticks),
    .lane_steering(in_data.lane_steering),
    .stage_mid    (stage_mid),
    .first_mid    (first_next),
    .second_mid   (second_next),
    .speed        (speed),
    .steer        (steer)
  );

  omc_measure #(.COUNT_WIDTH(COUNT_WIDTH)) u_measure (
    .stage_mid   (stage_mid),
    .first_ticks (first_next),
    .second_ticks(second_next),
    .sample      (in_data),
    .cfg         (cfg),
    .stage_next  (stage_next)
  );

  // State commits only on a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.mv          <= MV_FORWARD;
      stage.ms          <= MS_FIND_INIT;
      stage.prev_fc     <= '0;
      first_turn_ticks  <= '0;
      second_turn_ticks <= '0;
    end else if (accept) begin
      stage             <= stage_next;
      first_turn_ticks  <= first_next;
      second_turn_ticks <= second_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.speed_tenths    <= speed;
      out_data.steering_out    <= steer;
      out_data.moving_state    <= stage_next.mv;
      out_data.measuring_state <= stage_next.ms;
    end
  end

`ifndef NO_ASSERTIONS
  // Forward is only entered with both turn counters run down
  a_forward_counters_zero: assert property (@(posedge clk) disable iff (rst)
    (stage.mv == MV_FORWARD) |-> (first_turn_ticks == '0 && second_turn_ticks == '0))
    else $error("turn counters not zero in forward");

  // Every transfer leaves a result in the output register
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid && out_data.moving_state == $past(stage_next.mv)))
    else $error("transferred tick produced no result");

  // Right-lane right turn only counts the first counter down
  a_right_turn_counts_down: assert property (@(posedge clk) disable iff (rst)
    (accept && stage.mv == MV_RIGHT_RIGHT) |=>
      (first_turn_ticks <= $past(first_turn_ticks)))
    else $error("first counter rose during right turn");

  // State holds without a transfer
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(stage))
    else $error("state changed without a transfer");
`endif

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for overtaking_maneuver_controller_core.
// Needs omc_pkg and the core RTL; a built-in predictor tracks both machines
// and checks every result transfer, with APB register writes between phases.
`timescale 1ns / 1ps
module testbench;
  import omc_pkg::*;

  localparam int         CNT_W     = 16;
  localparam logic [1:0] REG_SPARE = 2'd3;  // decoded address with no register behind it

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  omc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  omc_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  overtaking_maneuver_controller_core #(.COUNT_WIDTH(CNT_W)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predicted controller state and register contents
  move_state_t      pred_move = MV_FORWARD;
  measure_state_t   pred_measure = MS_FIND_INIT;
  logic [CNT_W-1:0] out_turn_ticks = '0;    // ticks spent swerving left
  logic [CNT_W-1:0] align_turn_ticks = '0;  // ticks spent turning back parallel
  int               last_front = 0;
  int               trigger_lim = 450;
  int               parallel_lim = 130;
  int               approach_lim = 1;
  omc_out_t         expected_results[$];

  int send_idle_pct = 38;
  int recv_idle_pct = 38;
  int hold_left = 0;
  int mismatch_count = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int overtakes_done = 0;
  int cfg_writes = 0;

  function automatic int gap_abs(int a, int b);
    int d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  // One control tick: moving machine first, then measuring machine on the
  // measuring state the moving machine left behind.
  function automatic void advance_maneuver(omc_in_t t);
    int fc, fr, irf, irr;
    omc_out_t r;
    fc  = int'(t.front_center_distance);
    fr  = int'(t.front_right_distance);
    irf = int'(t.ir_front_right);
    irr = int'(t.ir_rear_right);
    r.speed_tenths = SPEED_NONE;
    r.steering_out = STEER_STRAIGHT;

    case (pred_move)
      MV_FORWARD: begin
        r.speed_tenths = SPEED_FAST;
        r.steering_out = t.lane_steering;
        out_turn_ticks = '0;
        align_turn_ticks = '0;
      end
      MV_LEFT_LEFT: begin
        r.speed_tenths = SPEED_TURN;
        r.steering_out = STEER_LEFT_HARD;
        pred_measure = MS_HAVE_BOTH_IR;
        if (out_turn_ticks != '1) out_turn_ticks = out_turn_ticks + 1'b1;
      end
      MV_LEFT_RIGHT: begin
        r.speed_tenths = SPEED_TURN;
        r.steering_out = STEER_RIGHT;
        pred_measure = MS_IR_SAME_DIST;
        if (align_turn_ticks != '1) align_turn_ticks = align_turn_ticks + 1'b1;
      end
      MV_CONTINUE_LEFT: begin
        r.speed_tenths = SPEED_FAST;
        r.steering_out = STEER_STRAIGHT;
        pred_measure = MS_END_OF_OBJECT;
      end
      MV_RIGHT_RIGHT: begin
        r.speed_tenths = SPEED_TURN;
        r.steering_out = STEER_RIGHT_LOW;
        if (out_turn_ticks != '0) out_turn_ticks = out_turn_ticks - 1'b1;
        if (out_turn_ticks == '0) pred_move = MV_RIGHT_LEFT;
      end
      MV_RIGHT_LEFT: begin
        r.speed_tenths = SPEED_SLOW;
        r.steering_out = STEER_LEFT_HARD;
        if (align_turn_ticks != '0) align_turn_ticks = align_turn_ticks - 1'b1;
        if (align_turn_ticks == '0) begin
          pred_move = MV_FORWARD;
          pred_measure = MS_FIND_INIT;
          last_front = 0;
          overtakes_done++;
        end
      end
      default: ;
    endcase

    case (pred_measure)
      MS_FIND_INIT: begin
        last_front = fc;
        pred_measure = MS_FIND;
      end
      MS_FIND: begin
        if (fc > 0 && ((last_front - fc) > 0 || gap_abs(last_front, fc) < approach_lim))
          pred_measure = MS_FIND_PLAUS;
        last_front = fc;
      end
      MS_FIND_PLAUS: begin
        // a missing echo reads negative, so it always starts the swerve
        if (fc < trigger_lim) begin
          pred_move = MV_LEFT_LEFT;
          pred_measure = MS_DISABLED;
        end else begin
          pred_measure = MS_FIND;
        end
      end
      MS_HAVE_BOTH_IR: begin
        if (irf > 0 && irr > 0) pred_move = MV_LEFT_RIGHT;
      end
      MS_IR_SAME_DIST: begin
        if (gap_abs(irf, irr) < parallel_lim && align_turn_ticks > out_turn_ticks)
          pred_move = MV_CONTINUE_LEFT;
      end
      MS_END_OF_OBJECT: begin
        if (fr < 0) begin
          pred_move = MV_RIGHT_RIGHT;
          pred_measure = MS_DISABLED;
        end
      end
      default: ;
    endcase

    r.moving_state = pred_move;
    r.measuring_state = pred_measure;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Random tick, mostly nudged toward the next step of an overtake.
  // With push set, always nudged.
  function automatic omc_in_t shape_tick(bit push);
    omc_in_t t;
    int fc, d;
    t.lane_steering         = 16'($urandom);
    t.front_center_distance = 16'($urandom);
    t.front_right_distance  = 16'($urandom);
    t.ir_front_right        = 16'($urandom);
    t.ir_rear_right         = 16'($urandom);
    if (push || $urandom_range(99) < 75) begin
      case (pred_measure)
        MS_FIND_INIT: t.front_center_distance = 16'($urandom_range(32767, 1));
        MS_FIND: begin
          if (last_front > 1 && $urandom_range(3) != 0)
            fc = last_front - int'($urandom_range((last_front > 200) ? 200 : last_front - 1, 1));
          else if (last_front > 0)
            fc = last_front;
          else
            fc = int'($urandom_range(3000, 1));
          t.front_center_distance = 16'(fc);
        end
        MS_FIND_PLAUS: begin
          if (push || $urandom_range(99) < 80) begin
            if (trigger_lim > 1 && $urandom_range(3) != 0)
              fc = int'($urandom_range(trigger_lim - 1, 1));
            else
              fc = -int'($urandom_range(32768, 1));
          end else begin
            fc = int'($urandom_range(32767, trigger_lim));
          end
          t.front_center_distance = 16'(fc);
        end
        MS_HAVE_BOTH_IR: begin
          if (push || $urandom_range(99) < 35) begin
            t.ir_front_right = 16'($urandom_range(32767, 1));
            t.ir_rear_right  = 16'($urandom_range(32767, 1));
          end else if ($urandom_range(1)) begin
            t.ir_front_right[15] = 1'b1;
          end else begin
            t.ir_rear_right[15] = 1'b1;
          end
        end
        MS_IR_SAME_DIST: begin
          d  = (parallel_lim > 0) ? int'($urandom_range(parallel_lim - 1)) : 0;
          fc = int'($urandom_range(3000, 1));
          t.ir_rear_right = 16'(fc);
          fc = $urandom_range(1) ? fc + d : fc - d;
          if (fc > 32767) fc = 32767;
          t.ir_front_right = 16'(fc);
        end
        MS_END_OF_OBJECT:
          t.front_right_distance[15] = push || ($urandom_range(99) < 30);
        default: ;
      endcase
    end
    return t;
  endfunction

  // Offer one tick and hold it until the transfer; may leave a random gap after.
  task automatic send_tick(omc_in_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    advance_maneuver(t);
    ticks_sent++;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_reading(int lane, int fc, int fr, int irf, int irr);
    omc_in_t t;
    t.lane_steering         = 16'(lane);
    t.front_center_distance = 16'(fc);
    t.front_right_distance  = 16'(fr);
    t.ir_front_right        = 16'(irf);
    t.ir_rear_right         = 16'(irr);
    send_tick(t);
  endtask

  // Stop offering and wait for every outstanding result, then let the clock run on.
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_TRIGGER) trigger_lim = int'(value[14:0]);
    else if (idx == REG_PARALLEL) parallel_lim = int'(value[14:0]);
    else if (idx == REG_APPROACH) approach_lim = int'(value[14:0]);
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_read(logic [1:0] idx, output logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_registers();
    logic [31:0] got;
    logic [1:0]  idx;
    int want;
    for (int i = int'(REG_TRIGGER); i <= int'(REG_APPROACH); i++) begin
      idx = 2'(i);
      cfg_read(idx, got);
      want = (idx == REG_TRIGGER) ? trigger_lim :
             (idx == REG_PARALLEL) ? parallel_lim : approach_lim;
      if (got[14:0] !== want[14:0]) begin
        mismatch_count++;
        $display("%0t: register %0d read expected %0d, got %0d", $time, i, want, got[14:0]);
      end
    end
  endtask

  // Low 15 bits carry the value; upper bits are junk the block must drop.
  function automatic logic [31:0] with_junk(int value);
    return ($urandom & 32'hFFFF_8000) | 32'(value[14:0]);
  endfunction

  task automatic run_phase(int trig, int par, int appr, int n, int idle_pct);
    wait_drained();
    cfg_write(REG_TRIGGER, with_junk(trig));
    cfg_write(REG_PARALLEL, with_junk(par));
    cfg_write(REG_APPROACH, with_junk(appr));
    check_registers();
    send_idle_pct = idle_pct;
    recv_idle_pct = idle_pct;
    repeat (n) send_tick(shape_tick(1'b0));
  endtask

  task automatic test_register_access();
    check_registers();
    cfg_write(REG_TRIGGER, 32'hFFFF_FFFF);
    cfg_write(REG_PARALLEL, 32'h8000_0000);
    cfg_write(REG_APPROACH, 32'h1234_5678);
    check_registers();
    cfg_write(REG_SPARE, $urandom);   // must not land in any register
    check_registers();
    cfg_write(REG_TRIGGER, with_junk(int'(TRIGGER_RESET)));
    cfg_write(REG_PARALLEL, with_junk(int'(PARALLEL_RESET)));
    cfg_write(REG_APPROACH, with_junk(int'(APPROACH_RESET)));
    check_registers();
  endtask

  // One clean overtake at the reset settings, walking through each state and
  // touching the field extremes on the way.
  task automatic test_directed_overtake();
    send_reading( 32767,   1000,     0,      0,     0);  // remember distance
    send_reading(-32768,   1000,     0,      0,     0);  // unchanged counts as approach
    send_reading(     1,   1000,     0,      0,     0);  // too far, back to searching
    send_reading(    -1,  32767,     0,      0,     0);  // moving away
    send_reading(   100,    500,     0,      0,     0);  // closing in
    send_reading(     0,     -1,     0,      0,     0);  // no echo starts the swerve
    send_reading(     0,      0,     0, -32768, 32767);  // only one infrared sees
    send_reading(     0,      0,     0,  32767,     1);  // both see, turn back
    send_reading(     0,      0,     0,    300,   310);  // close, count too low
    send_reading(     0,      0,     0,    300,   310);
    send_reading(     0,      0,     0,    300,   430);  // count ok, gap at tolerance
    send_reading(     0,      0,     0,    300,   429);  // parallel
    send_reading(     0,      0,     0,      0,     0);  // front right still sees
    send_reading(     0,      0, 32767,      0,     0);
    send_reading(     0,      0,-32768,      0,     0);  // end of obstacle
    repeat (7) send_reading(0, 0, 0, 0, 0);              // unwind both counters
    send_reading(   -77,      0,     0,      0,     0);  // zero reading is no approach
  endtask

  task automatic test_random_phases();
    run_phase(int'(TRIGGER_RESET), int'(PARALLEL_RESET), int'(APPROACH_RESET), 200, 38);
    run_phase(0, 0, 0, 150, 38);
    run_phase(32767, 32767, 32767, 200, 38);
    run_phase($urandom_range(2000, 100), $urandom_range(400, 1), $urandom_range(60, 1), 250, 0);
    run_phase($urandom_range(32767), $urandom_range(32767), $urandom_range(32767), 200, 38);
    run_phase(int'(TRIGGER_RESET), int'(PARALLEL_RESET), int'(APPROACH_RESET), 200, 38);
  endtask

  // Receiver holds off for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    wait_drained();
    send_idle_pct = 0;
    @(posedge clk);
    hold_left = 80;
    @(negedge clk);
    repeat (30) send_tick(shape_tick(1'b0));
    wait_drained();
    send_idle_pct = 38;
    recv_idle_pct = 38;
    repeat (20) send_tick(shape_tick(1'b0));
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void flag_field(string name, logic signed [31:0] want,
                                     logic signed [31:0] got);
    mismatch_count++;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
  endfunction

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    omc_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, expected none, got %h",
                 $time, out_data);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        results_checked++;
        if (out_data.speed_tenths !== want.speed_tenths)
          flag_field("speed_tenths", 32'(want.speed_tenths), 32'(out_data.speed_tenths));
        if (out_data.steering_out !== want.steering_out)
          flag_field("steering_out", 32'(want.steering_out), 32'(out_data.steering_out));
        if (out_data.moving_state !== want.moving_state)
          flag_field("moving_state", 32'(want.moving_state), 32'(out_data.moving_state));
        if (out_data.measuring_state !== want.measuring_state)
          flag_field("measuring_state", 32'(want.measuring_state),
                     32'(out_data.measuring_state));
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_register_access();
    test_directed_overtake();
    test_random_phases();
    test_backpressure();
    wait_drained();
    repeat (5) @(negedge clk);
    $display("Covered %0d ticks and %0d checked results, with %0d complete overtakes,",
             ticks_sent, results_checked, overtakes_done);
    $display("%0d register writes across extreme settings and long receiver stalls.",
             cfg_writes);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
design/omc_pkg.sv
design/omc_move.sv
design/omc_measure.sv
design/overtaking_maneuver_controller_core.sv
tb/sv/testbench.sv
